@@ src/sec_pkg.sv @@
// Shared types and constants for the sortition eligibility check.
// Used by the front stage, the divider cells, the top level and the checker.
package sec_pkg;

  localparam int unsigned SCORE_W   = 64;
  localparam int unsigned ROUND_W   = 32;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned SHIFT_W   = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_ACT_CNT              = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_NUMERATOR   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_DENOMINATOR = 8'd2;

  typedef struct packed {
    logic [SCORE_W-1:0] score_head;
    logic [ROUND_W-1:0] round_number;
  } in_beat_t;

  typedef struct packed {
    logic               eligible;
    logic [SCORE_W-1:0] threshold;
  } out_beat_t;

  typedef struct packed {
    logic [CFG_W-1:0] act_cnt;
    logic [CFG_W-1:0] expected_numerator;
    logic [CFG_W-1:0] expected_denominator;
  } cfg_regs_t;

  typedef struct packed {
    logic               act_zero;
    logic               sat;
    logic               n_zero;
    logic [SCORE_W-1:0] score;
    logic [SCORE_W-1:0] d;
    logic [SCORE_W-1:0] rem;
    logic [SCORE_W-1:0] lo;
    logic [SCORE_W-1:0] q;
  } div_word_t;

endpackage

@@ src/sec_front.sv @@
// Front stages: round cap, numerator shift, denominator product, then
// saturation flags and the 128-bit dividend split. Depends on sec_pkg.
module sec_front #(
  parameter int unsigned ROUND_SHIFT_CAP = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  sec_pkg::in_beat_t   in_beat,
  input  sec_pkg::cfg_regs_t  cfg,
  output logic                out_valid,
  output sec_pkg::div_word_t  out_word
);

  localparam logic [sec_pkg::SHIFT_W-1:0] CAP_SH = sec_pkg::SHIFT_W'(ROUND_SHIFT_CAP);

  logic                          a_valid_r;
  logic                          a_act_zero_r;
  logic [sec_pkg::SCORE_W-1:0]   a_score_r;
  logic [sec_pkg::SCORE_W-1:0]   a_n_r;
  logic [sec_pkg::SCORE_W-1:0]   a_d_r;
  logic                          b_valid_r;
  sec_pkg::div_word_t            b_word_r;

  logic [sec_pkg::SHIFT_W-1:0]   shift_amt;
  logic [sec_pkg::CFG_W-1:0]     den_fix;
  logic [sec_pkg::SCORE_W-1:0]   a_n_nxt;
  logic [sec_pkg::SCORE_W-1:0]   a_d_nxt;
  sec_pkg::div_word_t            b_word_nxt;

  always_comb begin
    shift_amt = (in_beat.round_number < sec_pkg::ROUND_W'(ROUND_SHIFT_CAP)) ?
                in_beat.round_number[sec_pkg::SHIFT_W-1:0] : CAP_SH;
    den_fix   = (cfg.expected_denominator == '0) ? sec_pkg::CFG_W'(1)
                                                 : cfg.expected_denominator;
    a_n_nxt   = sec_pkg::SCORE_W'(cfg.expected_numerator) << shift_amt;
    a_d_nxt   = sec_pkg::SCORE_W'(den_fix) * sec_pkg::SCORE_W'(cfg.act_cnt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_act_zero_r <= (cfg.act_cnt == '0);
      a_score_r    <= in_beat.score_head;
      a_n_r        <= a_n_nxt;
      a_d_r        <= a_d_nxt;
    end
  end

  always_comb begin
    b_word_nxt.act_zero = a_act_zero_r;
    b_word_nxt.sat      = (a_n_r >= a_d_r);
    b_word_nxt.n_zero   = (a_n_r == '0);
    b_word_nxt.score    = a_score_r;
    b_word_nxt.d        = a_d_r;
    b_word_nxt.rem      = a_n_r - sec_pkg::SCORE_W'(1);
    b_word_nxt.lo       = '0 - a_n_r;
    b_word_nxt.q        = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_word_r <= b_word_nxt;
    end
  end

  assign out_valid = b_valid_r;
  assign out_word  = b_word_r;

endmodule

@@ src/sec_div_cell.sv @@
// One restoring-division cell: develops one quotient bit per beat.
// Depends on sec_pkg.
module sec_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  sec_pkg::div_word_t  in_word,
  output logic                out_valid,
  output sec_pkg::div_word_t  out_word
);

  logic                        valid_r;
  sec_pkg::div_word_t          word_r;
  sec_pkg::div_word_t          word_nxt;
  logic [sec_pkg::SCORE_W-1:0] rem_sh;
  logic                        take;

  always_comb begin
    rem_sh   = {in_word.rem[sec_pkg::SCORE_W-2:0], in_word.lo[sec_pkg::SCORE_W-1]};
    take     = in_word.rem[sec_pkg::SCORE_W-1] || (rem_sh >= in_word.d);
    word_nxt = in_word;
    word_nxt.rem = take ? (rem_sh - in_word.d) : rem_sh;
    word_nxt.lo  = {in_word.lo[sec_pkg::SCORE_W-2:0], 1'b0};
    word_nxt.q   = {in_word.q[sec_pkg::SCORE_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

@@ src/sortition_eligibility_check.sv @@
// Top level of the sortition eligibility check: config registers, front
// stages, a chain of 64 divider cells and the output register. Uses sec_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one score and round per
//   beat; output channel (out_valid/out_ready/out_data) returns one eligible
//   flag and threshold per input beat, in order.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
//   index 0 active count, 1 expected numerator, 2 expected denominator;
//   other indexes are dropped. Write only while no item is in flight.
//   A result passes two front stages (shift, product, compare), one cell per
//   quotient bit of the 128-by-64 division and one output register, 67
//   registers in all. Throughput is one beat per cycle unless the receiver
//   stalls; every stage holds its own item.
//   When the receiver stalls with a result waiting, the whole pipe holds and
//   in_ready falls in the same cycle; it resumes on the next out_ready.
//   Synchronous reset empties the pipe and loads active count 0, numerator 1
//   and denominator 1.
module sortition_eligibility_check #(
  parameter int unsigned ROUND_SHIFT_CAP = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sec_pkg::in_beat_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output sec_pkg::out_beat_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sec_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sec_pkg::CFG_W-1:0]        cfg_data
);

  sec_pkg::cfg_regs_t  cfg_r;
  logic                pipe_en;
  logic                chain_v [0:sec_pkg::DIV_STEPS];
  sec_pkg::div_word_t  chain_w [0:sec_pkg::DIV_STEPS];
  sec_pkg::div_word_t  last_w;
  logic                out_valid_r;
  sec_pkg::out_beat_t  out_data_r;
  sec_pkg::out_beat_t  out_data_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.act_cnt              <= '0;
      cfg_r.expected_numerator   <= sec_pkg::CFG_W'(1);
      cfg_r.expected_denominator <= sec_pkg::CFG_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sec_pkg::CFG_ACT_CNT:              cfg_r.act_cnt              <= cfg_data;
        sec_pkg::CFG_EXPECTED_NUMERATOR:   cfg_r.expected_numerator   <= cfg_data;
        sec_pkg::CFG_EXPECTED_DENOMINATOR: cfg_r.expected_denominator <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pipe_en  = out_ready || !out_valid_r;
  assign in_ready = pipe_en;

  sec_front #(
    .ROUND_SHIFT_CAP (ROUND_SHIFT_CAP)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (in_valid),
    .in_beat   (in_data),
    .cfg       (cfg_r),
    .out_valid (chain_v[0]),
    .out_word  (chain_w[0])
  );

  for (genvar i = 0; i < sec_pkg::DIV_STEPS; i++) begin : g_cell
    sec_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (pipe_en),
      .in_valid  (chain_v[i]),
      .in_word   (chain_w[i]),
      .out_valid (chain_v[i+1]),
      .out_word  (chain_w[i+1])
    );
  end

  assign last_w = chain_w[sec_pkg::DIV_STEPS];

  always_comb begin
    priority if (last_w.act_zero) begin
      out_data_nxt.threshold = '0;
    end else if (last_w.sat) begin
      out_data_nxt.threshold = '1;
    end else if (last_w.n_zero) begin
      out_data_nxt.threshold = '0;
    end else begin
      out_data_nxt.threshold = last_w.q;
    end
    out_data_nxt.eligible = !last_w.act_zero && (last_w.score <= out_data_nxt.threshold);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= chain_v[sec_pkg::DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ src/sec_checker.sv @@
// Port-level checks for the sortition eligibility check, bound to the top.
// Depends on sec_pkg and sortition_eligibility_check.
module sec_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input sec_pkg::out_beat_t out_data
);

  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (out_ready || !out_valid))
    else $error("in_ready does not track the output register");

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_saturated_eligible: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.threshold == '1) |-> out_data.eligible)
    else $error("all-ones threshold but not eligible");

endmodule

bind sortition_eligibility_check sec_checker u_sec_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
